/* rtl/core/dvr_pkg.sv */
// Package for the distance-vector route update engine.
// Holds the sizes, operation codes and sequencer states used by the engine top level.
package dvr_pkg;

  localparam int NODE_CNT  = 16;
  localparam int NODE_BITS = $clog2(NODE_CNT);
  localparam int COST_BITS = 16;
  localparam int VEC_DEPTH = NODE_CNT * NODE_CNT;
  localparam int VEC_ABITS = $clog2(VEC_DEPTH);

  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_LINK  = 2'd0,
    OP_VEC   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEST,
    ST_SCAN,
    ST_WAIT,
    ST_UPD
  } state_t;

endpackage

/* rtl/core/dvr_in_if.sv */
// Input channel of the route engine: valid/ready handshake and one update item.
// Depends on nothing.
interface dvr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  neighbor;
  logic [3:0]  dest;
  logic [15:0] cost;
  logic        cost_known;
  logic        first_entry;
  logic        last_entry;

  modport source (output valid, op, neighbor, dest, cost, cost_known, first_entry,
                  last_entry, input ready);
  modport sink (input valid, op, neighbor, dest, cost, cost_known, first_entry,
                last_entry, output ready);
endinterface

/* rtl/core/dvr_out_if.sv */
// Output channel of the route engine: valid/ready handshake and one result item.
// Depends on nothing.
interface dvr_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic [3:0]  next_hop;
  logic        hop_known;
  logic [15:0] route_cost;
  logic        route_known;

  modport source (output valid, changed, next_hop, hop_known, route_cost, route_known,
                  input ready);
  modport sink (input valid, changed, next_hop, hop_known, route_cost, route_known,
                output ready);
endinterface

/* rtl/core/dvr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/distance_vector_route_update.sv */
// Distance-vector route update engine, top level.
// Query and plain vector entries are taken in ST_IDLE; a query's result is registered.
// Link update or last vector entry: recompute walks each destination; a known
// non-self destination passes ST_DEST, ST_SCAN (one vector RAM read per neighbor),
// ST_WAIT and ST_UPD, others only ST_DEST; no input is taken until the walk ends.
// Synchronous reset clears all valid bits, self_id and the sequencer; table and
// vector RAM contents stay as they are and are masked by their valid bits.
module distance_vector_route_update (
  input  logic        clk,
  input  logic        rst,
  dvr_in_if.sink      in_ch,
  dvr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NB = dvr_pkg::NODE_BITS;
  localparam int CB = dvr_pkg::COST_BITS;

  dvr_pkg::state_t state, state_next;

  // configuration
  logic [3:0] self_id;

  // small tables, one entry per node
  logic [CB-1:0] link_cost [dvr_pkg::NODE_CNT];
  logic [dvr_pkg::NODE_CNT-1:0] link_vld;
  logic [CB-1:0] route_cost [dvr_pkg::NODE_CNT];
  logic [dvr_pkg::NODE_CNT-1:0] route_vld;
  logic [NB-1:0] hop_id [dvr_pkg::NODE_CNT];
  logic [dvr_pkg::NODE_CNT-1:0] hop_vld;
  logic [dvr_pkg::NODE_CNT-1:0] dest_known;

  // valid bits of the advertised vector store; costs live in the RAM
  logic [dvr_pkg::VEC_DEPTH-1:0] vec_vld;

  // recompute walk
  logic [NB-1:0] d_cnt;
  logic [NB-1:0] n_cnt;
  logic [NB-1:0] n_q;
  logic          acc_en;
  logic          found;
  logic [CB-1:0] best;
  logic [NB-1:0] best_hop;
  logic          any_chg;

  // output register
  logic        o_vld;
  logic        o_changed;
  logic [3:0]  o_hop;
  logic        o_hop_known;
  logic [15:0] o_cost;
  logic        o_cost_known;

  logic                       in_ready;
  logic                       acc;
  logic                       out_free;
  logic                       ram_we;
  logic [dvr_pkg::VEC_ABITS-1:0] ram_waddr;
  logic [CB-1:0]              ram_wdata;
  logic [dvr_pkg::VEC_ABITS-1:0] ram_raddr;
  logic [CB-1:0]              ram_rdata;
  logic [CB-1:0]              in_cost;
  logic [NB-1:0]              in_nb;
  logic [NB-1:0]              in_dst;
  logic                       start_rc;
  logic                       d_last;
  logic                       d_self;
  logic [CB:0]                sum;
  logic [CB-1:0]              sum_sat;
  logic                       cand_ok;

  assign in_nb   = in_ch.neighbor[NB-1:0];
  assign in_dst  = in_ch.dest[NB-1:0];
  assign in_cost = in_ch.cost[CB-1:0];

  assign out_free = !o_vld || out_ch.ready;
  assign acc      = in_ch.valid && in_ready;
  assign start_rc = acc && ((in_ch.op == dvr_pkg::OP_LINK) ||
                            ((in_ch.op == dvr_pkg::OP_VEC) && in_ch.last_entry));
  assign d_last   = (d_cnt == NB'(dvr_pkg::NODE_CNT - 1));
  assign d_self   = ({{(8-NB){1'b0}}, d_cnt} == {4'b0, self_id});

  // candidate from the read that returned this cycle
  assign sum     = {1'b0, link_cost[n_q]} + {1'b0, ram_rdata};
  assign sum_sat = sum[CB] ? dvr_pkg::COST_MAX : sum[CB-1:0];
  assign cand_ok = acc_en && link_vld[n_q] && vec_vld[{n_q, d_cnt}];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      dvr_pkg::ST_IDLE: begin
        if (start_rc) begin
          state_next = dvr_pkg::ST_DEST;
        end
      end
      dvr_pkg::ST_DEST: begin
        if (dest_known[d_cnt] && !d_self) begin
          state_next = dvr_pkg::ST_SCAN;
        end else if (d_last) begin
          state_next = dvr_pkg::ST_IDLE;
        end
      end
      dvr_pkg::ST_SCAN: begin
        if (n_cnt == NB'(dvr_pkg::NODE_CNT - 1)) begin
          state_next = dvr_pkg::ST_WAIT;
        end
      end
      dvr_pkg::ST_WAIT: state_next = dvr_pkg::ST_UPD;
      dvr_pkg::ST_UPD: begin
        state_next = d_last ? dvr_pkg::ST_IDLE : dvr_pkg::ST_DEST;
      end
      default: state_next = dvr_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State outputs: handshake and RAM ports
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    ram_raddr = {n_cnt, d_cnt};
    unique case (state)
      dvr_pkg::ST_IDLE: in_ready = out_free;
      default:          in_ready = 1'b0;
    endcase
  end

  // Vector store writes happen only on accepted items, never during a walk.
  always_comb begin
    ram_we    = acc && ((in_ch.op == dvr_pkg::OP_LINK) || (in_ch.op == dvr_pkg::OP_VEC));
    ram_waddr = {in_nb, in_nb};
    ram_wdata = '0;
    if (in_ch.op == dvr_pkg::OP_VEC) begin
      ram_waddr = {in_nb, in_dst};
      ram_wdata = in_ch.cost_known ? in_cost : '0;
    end
  end

  dvr_ram #(
    .WIDTH (CB),
    .DEPTH (dvr_pkg::VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Tables and walk registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id    <= '0;
      link_vld   <= '0;
      route_vld  <= '0;
      hop_vld    <= '0;
      dest_known <= '0;
      vec_vld    <= '0;
      acc_en     <= 1'b0;
      o_vld      <= 1'b0;
      d_cnt      <= '0;
      n_cnt      <= '0;
      found      <= 1'b0;
      any_chg    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        self_id <= pwdata[3:0];
      end

      if (out_ch.ready) begin
        o_vld <= 1'b0;
      end

      acc_en <= (state == dvr_pkg::ST_SCAN);
      n_q    <= n_cnt;

      // fold in the candidate that arrives from the RAM this cycle
      if (cand_ok && (!found || sum_sat < best)) begin
        best     <= sum_sat;
        best_hop <= n_q;
        found    <= 1'b1;
      end

      unique case (state)
        dvr_pkg::ST_IDLE: begin
          d_cnt   <= '0;
          any_chg <= 1'b0;
          if (acc) begin
            unique case (in_ch.op)
              dvr_pkg::OP_LINK: begin
                link_cost[in_nb]       <= in_cost;
                link_vld[in_nb]        <= 1'b1;
                route_vld[in_nb]       <= 1'b0;
                route_cost[in_nb]      <= '0;
                vec_vld[{in_nb, in_nb}] <= 1'b1;
                dest_known[in_nb]      <= 1'b1;
              end
              dvr_pkg::OP_VEC: begin
                // clear the sender's row first, the entry below then wins
                if (in_ch.first_entry) begin
                  for (int k = 0; k < dvr_pkg::NODE_CNT; k++) begin
                    vec_vld[{in_nb, NB'(k)}] <= 1'b0;
                  end
                end
                vec_vld[{in_nb, in_dst}] <= in_ch.cost_known;
                dest_known[in_dst]       <= 1'b1;
              end
              dvr_pkg::OP_QUERY: begin
                o_vld        <= 1'b1;
                o_changed    <= 1'b0;
                o_hop        <= hop_vld[in_dst] ? 4'(hop_id[in_dst]) : 4'd0;
                o_hop_known  <= hop_vld[in_dst];
                o_cost       <= route_vld[in_dst] ? 16'(route_cost[in_dst]) : 16'd0;
                o_cost_known <= route_vld[in_dst];
              end
              default: ;
            endcase
          end
        end
        dvr_pkg::ST_DEST: begin
          n_cnt <= '0;
          found <= 1'b0;
          if (dest_known[d_cnt] && d_self) begin
            route_cost[d_cnt] <= '0;
            route_vld[d_cnt]  <= 1'b1;
          end
          if (!dest_known[d_cnt] || d_self) begin
            d_cnt <= d_cnt + 1'b1;
            if (d_last) begin
              o_vld        <= 1'b1;
              o_changed    <= any_chg;
              o_hop        <= '0;
              o_hop_known  <= 1'b0;
              o_cost       <= '0;
              o_cost_known <= 1'b0;
            end
          end
        end
        dvr_pkg::ST_SCAN: begin
          n_cnt <= n_cnt + 1'b1;
        end
        dvr_pkg::ST_WAIT: ;
        dvr_pkg::ST_UPD: begin
          if (found && (!route_vld[d_cnt] || route_cost[d_cnt] != best)) begin
            route_cost[d_cnt] <= best;
            route_vld[d_cnt]  <= 1'b1;
            hop_id[d_cnt]     <= best_hop;
            hop_vld[d_cnt]    <= 1'b1;
          end
          d_cnt <= d_cnt + 1'b1;
          if (d_last) begin
            o_vld        <= 1'b1;
            o_changed    <= any_chg ||
                            (found && (!route_vld[d_cnt] || route_cost[d_cnt] != best));
            o_hop        <= '0;
            o_hop_known  <= 1'b0;
            o_cost       <= '0;
            o_cost_known <= 1'b0;
          end else begin
            any_chg <= any_chg ||
                       (found && (!route_vld[d_cnt] || route_cost[d_cnt] != best));
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = o_vld;
  assign out_ch.changed     = o_changed;
  assign out_ch.next_hop    = o_hop;
  assign out_ch.hop_known   = o_hop_known;
  assign out_ch.route_cost  = o_cost;
  assign out_ch.route_known = o_cost_known;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, self_id};

endmodule

/* tb/distance_vector_route_update_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the distance-vector route update engine.
// Uses dvr_pkg and the dvr_in_if / dvr_out_if channel interfaces of the RTL.
module distance_vector_route_update_test;

  localparam int IDLE_LIMIT  = 20000; // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 400;   // settle time that covers the worst recompute
  localparam int LONG_HOLD   = 3000;  // receiver hold-off that backs the engine up
  localparam logic [2:0] ADDR_SELF_ID = 3'd0;

  typedef struct packed {
    dvr_pkg::op_t op;
    logic [3:0]  neighbor;
    logic [3:0]  dest;
    logic [15:0] cost;
    logic        cost_known;
    logic        first_entry;
    logic        last_entry;
  } update_t;

  typedef struct packed {
    logic        changed;
    logic [3:0]  next_hop;
    logic        hop_known;
    logic [15:0] route_cost;
    logic        route_known;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dvr_in_if  in_ch ();
  dvr_out_if out_ch ();

  distance_vector_route_update u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the engine's tables.
  logic [3:0]  my_id;
  logic [15:0] link_cost [16];
  bit          link_ok   [16];
  logic [15:0] adv_cost  [256];
  bit          adv_ok    [256];
  logic [15:0] best_cost [16];
  bit          best_ok   [16];
  logic [3:0]  best_hop  [16];
  bit          hop_ok    [16];
  bit          dest_seen [16];

  update_t pending_updates[$];
  answer_t answers_due[$];
  int      mismatches = 0;
  int      answers_seen = 0;
  int      idle_cycles = 0;
  bit      in_taken = 1'b0;
  bit      out_taken = 1'b0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // Re-run Bellman-Ford over every known destination; report any route change.
  function automatic bit rebuild_routes();
    bit          any;
    bit          found;
    logic [16:0] sum;
    logic [15:0] low;
    logic [3:0]  via;
    any = 1'b0;
    for (int d = 0; d < 16; d++) begin
      if (!dest_seen[d]) continue;
      if (d == my_id) begin
        best_cost[d] = '0;
        best_ok[d]   = 1'b1;
        continue;
      end
      found = 1'b0;
      low   = '0;
      via   = '0;
      for (int n = 0; n < 16; n++) begin
        if (!link_ok[n] || !adv_ok[n*16+d]) continue;
        sum = {1'b0, link_cost[n]} + {1'b0, adv_cost[n*16+d]};
        if (sum[16]) sum = {1'b0, dvr_pkg::COST_MAX};
        // strict less-than keeps the lowest-numbered neighbor on a tie
        if (!found || sum[15:0] < low) begin
          low   = sum[15:0];
          via   = n[3:0];
          found = 1'b1;
        end
      end
      if (found && (!best_ok[d] || best_cost[d] != low)) begin
        best_cost[d] = low;
        best_ok[d]   = 1'b1;
        best_hop[d]  = via;
        hop_ok[d]    = 1'b1;
        any          = 1'b1;
      end
    end
    return any;
  endfunction

  // Apply one accepted update to the shadow tables; queue the answer it causes.
  function automatic void route_engine_predict(input update_t u);
    answer_t a;
    int      row;
    a   = '0;
    row = u.neighbor * 16;
    case (u.op)
      dvr_pkg::OP_LINK: begin
        link_cost[u.neighbor]       = u.cost;
        link_ok[u.neighbor]         = 1'b1;
        best_ok[u.neighbor]         = 1'b0;
        best_cost[u.neighbor]       = '0;
        adv_cost[row + u.neighbor]  = '0;
        adv_ok[row + u.neighbor]    = 1'b1;
        dest_seen[u.neighbor]       = 1'b1;
        a.changed = rebuild_routes();
        answers_due.push_back(a);
      end
      dvr_pkg::OP_VEC: begin
        if (u.first_entry)
          for (int k = 0; k < 16; k++) begin
            adv_ok[row + k]   = 1'b0;
            adv_cost[row + k] = '0;
          end
        adv_ok[row + u.dest]   = u.cost_known;
        adv_cost[row + u.dest] = u.cost_known ? u.cost : 16'd0;
        dest_seen[u.dest]      = 1'b1;
        if (u.last_entry) begin
          a.changed = rebuild_routes();
          answers_due.push_back(a);
        end
      end
      dvr_pkg::OP_QUERY: begin
        if (hop_ok[u.dest]) begin
          a.next_hop  = best_hop[u.dest];
          a.hop_known = 1'b1;
        end
        if (best_ok[u.dest]) begin
          a.route_cost  = best_cost[u.dest];
          a.route_known = 1'b1;
        end
        answers_due.push_back(a);
      end
      default: ; // no-op code: nothing stored, nothing returned
    endcase
  endfunction

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    in_taken  <= !rst && in_ch.valid && in_ch.ready;
    out_taken <= !rst && out_ch.valid && out_ch.ready;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        got = '{out_ch.changed, out_ch.next_hop, out_ch.hop_known,
                out_ch.route_cost, out_ch.route_known};
        if (answers_due.size() == 0) begin
          flag_mismatch("unexpected result", got, 0);
        end else begin
          want = answers_due.pop_front();
          if (got.changed !== want.changed)
            flag_mismatch("changed", got.changed, want.changed);
          if (got.next_hop !== want.next_hop)
            flag_mismatch("next_hop", got.next_hop, want.next_hop);
          if (got.hop_known !== want.hop_known)
            flag_mismatch("hop_known", got.hop_known, want.hop_known);
          if (got.route_cost !== want.route_cost)
            flag_mismatch("route_cost", got.route_cost, want.route_cost);
          if (got.route_known !== want.route_known)
            flag_mismatch("route_known", got.route_known, want.route_known);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        route_engine_predict('{dvr_pkg::op_t'(in_ch.op), in_ch.neighbor, in_ch.dest,
                               in_ch.cost, in_ch.cost_known, in_ch.first_entry,
                               in_ch.last_entry});
      end
    end
  end

  // Watchdog: count cycles in which nothing transfers on any port.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = dvr_pkg::OP_NONE;
    in_ch.neighbor = '0;
    in_ch.dest = '0;
    in_ch.cost = '0;
    in_ch.cost_known = 1'b0;
    in_ch.first_entry = 1'b0;
    in_ch.last_entry = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Driver: present pending updates at the falling edge, with random gaps.
  int  gap_left = 0;
  int  sent = 0;
  always @(negedge clk) begin
    update_t u;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the offered item until it is taken
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_updates.size() > 0) begin
      u = pending_updates.pop_front();
      in_ch.valid       <= 1'b1;
      in_ch.op          <= u.op;
      in_ch.neighbor    <= u.neighbor;
      in_ch.dest        <= u.dest;
      in_ch.cost        <= u.cost;
      in_ch.cost_known  <= u.cost_known;
      in_ch.first_entry <= u.first_entry;
      in_ch.last_entry  <= u.last_entry;
      sent++;
      // every other block of 150 items goes back to back
      gap_left <= ((sent / 150) % 2) ? 0 : $urandom_range(0, 19);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stall after each result, plus one long hold-off.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  held = 1'b0;
  always @(negedge clk) begin
    int draw;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && answers_seen == 150) begin
      // back the engine up while the driver keeps offering
      held <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (out_taken) begin
      draw = ((answers_seen / 100) % 3 == 2) ? 0 : $urandom_range(0, 19);
      stall_left <= draw;
      out_ch.ready <= (draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_self_id(input logic [3:0] id);
    apb_write(ADDR_SELF_ID, {28'd0, id});
    my_id = id;
  endtask

  task automatic queue_update(input dvr_pkg::op_t op, input int nb, input int dst,
                              input int cost, input bit known, input bit first,
                              input bit last);
    pending_updates.push_back('{op, nb[3:0], dst[3:0], cost[15:0], known, first, last});
  endtask

  // Let every queued update drain and the engine settle before reconfiguring.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_updates.size() != 0 || in_ch.valid !== 1'b0 || answers_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Random cost: mostly small so routes compete, sometimes near the top.
  function automatic int pick_cost();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535);
      1:       return $urandom_range(65000, 65535);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic queue_random(input int count);
    int done;
    int len;
    int nb;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_update(dvr_pkg::OP_LINK, $urandom_range(0, 15), $urandom_range(0, 15),
                     pick_cost(), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        done++;
      end else if (pick < 70) begin
        // well-formed vector message from one neighbor
        len = $urandom_range(1, 6);
        nb  = $urandom_range(0, 15);
        for (int i = 0; i < len; i++)
          queue_update(dvr_pkg::OP_VEC, nb, $urandom_range(0, 15), pick_cost(),
                       $urandom_range(0, 4) != 0, i == 0, i == len - 1);
        done += len;
      end else if (pick < 92) begin
        queue_update(dvr_pkg::OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 65535), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        done++;
      end else begin
        // noise: any code, flags unrelated to message boundaries
        queue_update(dvr_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 65535), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        if (pending_updates[$].op != dvr_pkg::OP_NONE) done++;
      end
    end
  endtask

  initial begin
    my_id = '0;
    for (int i = 0; i < 16; i++) begin
      link_cost[i] = '0; link_ok[i] = 0; best_cost[i] = '0; best_ok[i] = 0;
      best_hop[i] = '0; hop_ok[i] = 0; dest_seen[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      adv_cost[i] = '0; adv_ok[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_self_id(4'd0);
    // Directed: query before anything is known, links at both cost extremes,
    // self as neighbor, saturating sums, unknown entries, row clear, no-op code.
    queue_update(dvr_pkg::OP_QUERY, 0, 5, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_LINK, 1, 0, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_LINK, 2, 0, 65535, 1, 1, 1);
    queue_update(dvr_pkg::OP_LINK, 0, 0, 7, 0, 0, 0);
    queue_update(dvr_pkg::OP_VEC, 1, 9, 30, 1, 1, 0);
    queue_update(dvr_pkg::OP_VEC, 1, 15, 65535, 1, 0, 0);
    queue_update(dvr_pkg::OP_VEC, 1, 3, 0, 0, 0, 1);
    queue_update(dvr_pkg::OP_VEC, 2, 9, 65535, 1, 1, 1);
    queue_update(dvr_pkg::OP_VEC, 2, 9, 10, 1, 1, 1);
    queue_update(dvr_pkg::OP_VEC, 0, 9, 23, 1, 1, 1);
    queue_update(dvr_pkg::OP_VEC, 15, 0, 1, 1, 1, 1);
    queue_update(dvr_pkg::OP_QUERY, 0, 9, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_QUERY, 0, 15, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_QUERY, 15, 0, 65535, 1, 1, 1);
    queue_update(dvr_pkg::OP_QUERY, 0, 3, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_NONE, 15, 15, 65535, 1, 1, 1);
    queue_update(dvr_pkg::OP_VEC, 1, 9, 5, 1, 1, 0);
    queue_update(dvr_pkg::OP_NONE, 0, 0, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_VEC, 1, 4, 5, 1, 0, 1);
    queue_update(dvr_pkg::OP_LINK, 1, 0, 65535, 0, 0, 0);
    queue_update(dvr_pkg::OP_QUERY, 0, 9, 0, 0, 0, 0);
    queue_update(dvr_pkg::OP_QUERY, 0, 1, 0, 0, 0, 0);
    queue_random(450);
    wait_quiet();

    set_self_id(4'd15);
    queue_random(450);
    wait_quiet();

    set_self_id(4'($urandom_range(0, 15)));
    queue_random(450);
    wait_quiet();

    set_self_id(4'd9);
    queue_random(450);
    wait_quiet();

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/dvr_pkg.sv
rtl/core/dvr_in_if.sv
rtl/core/dvr_out_if.sv
rtl/core/dvr_ram.sv
rtl/core/distance_vector_route_update.sv
tb/distance_vector_route_update_test.sv
